>>> src/assert_macros.svh
// Assertion macros used by the lamp state classifier top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define LSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one at the next clock edge.
`define LSC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/lsc_pkg.sv
// Types and constants of the lamp state classifier.
package lsc_pkg;

    localparam int LANES       = 3;
    localparam int LEVEL_W     = 10;
    localparam int CODE_W      = 5;
    localparam int THR_W       = 10;
    localparam int OUT_FIELD_W = 3 * LEVEL_W + 2 * CODE_W + LEVEL_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(512);
    localparam logic [CODE_W-1:0] CODE_MAX    = CODE_W'(26);
    localparam logic [CODE_W-1:0] CODE_REPORT = CODE_W'(2);

    // Lamp digit of one channel
    typedef enum logic [1:0] {
        DIGIT_OFF   = 2'd0,
        DIGIT_BLINK = 2'd1,
        DIGIT_ON    = 2'd2
    } digit_t;

    // Code weight of each channel for a blinking and an on lamp
    localparam logic [LANES-1:0][CODE_W-1:0] BLINK_WEIGHT = {5'd9, 5'd3, 5'd1};
    localparam logic [LANES-1:0][CODE_W-1:0] ON_WEIGHT    = {5'd18, 5'd6, 5'd2};

    // Per-lane strobes from the top-level control
    typedef struct packed {
        logic q_load;   // input item accepted, latch scaled samples
        logic acc_add;  // add scaled samples to the accumulator
        logic win_end;  // last tick of the window, move level out
    } lane_ctl_t;

endpackage

>>> src/lamp_state_classifier.sv
// Lamp state classifier top level: three sensor lanes, control and result merge.
//
// Input stream (s_axis): one item per sampling tick, carrying the three converter
// samples sample_a, sample_b and sample_c in tdata. Every WINDOW_TICKS-th item closes
// a window and causes one result item; the other items cause none.
// Output stream (m_axis): averaged levels of the window, the raw base-3 lamp code,
// the filtered reported code and the reported value (level_a when the reported code
// is 2, else zero).
// Configuration (cfg): write on_threshold while the block is idle; cfg_ready is
// always high.
// Throughput: one input item per cycle while s_axis_tready is high. Each lane
// scales and accumulates its sample with one multiply and one add, each in a
// stage of its own. Result path: the window's last item is accumulated into
// level_reg, then classified and filtered into the output register.
// Reset: accumulators, tick count and filter state clear, on_threshold returns to
// 512, the first window code is reported at once.
// Stall: a waiting result sits in the output register while input items are still
// taken; a second finished window waits one stage earlier, and only if that stage
// is also held does s_axis_tready drop.
module lamp_state_classifier #(
    parameter int WINDOW_TICKS = 16,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_a, sample_b, sample_c from bit 0 up, zero padded to bytes
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // level_a, level_b, level_c, raw_code, reported_code, reported_value from bit 0 up
    output logic [lsc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lsc_pkg::THR_W-1:0]             cfg_data
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(WINDOW_TICKS);
    localparam logic [CNT_W-1:0] TICK_LAST = CNT_W'(WINDOW_TICKS - 1);

    logic [lsc_pkg::THR_W-1:0]                          thr_reg;
    logic                                               en;
    logic                                               a_valid_reg;
    logic                                               a_valid_next;
    logic [CNT_W-1:0]                                   tick_reg;
    logic [CNT_W-1:0]                                   tick_next;
    logic                                               win_valid_reg;
    logic                                               win_valid_next;
    logic                                               out_free;
    logic                                               win_move;
    lsc_pkg::lane_ctl_t                                 ctl;
    logic [lsc_pkg::LANES-1:0][SAMPLE_BITS-1:0]         samples;
    logic [lsc_pkg::LANES-1:0][SAMPLE_BITS-1:0]         levels_full;
    logic [lsc_pkg::LANES-1:0][lsc_pkg::LEVEL_W-1:0]    levels;
    lsc_pkg::digit_t [lsc_pkg::LANES-1:0]               digits;

    // Write the threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= lsc_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Advance the pipe unless a finished window is held behind a full output
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign win_move      = win_valid_reg && out_free;
    assign en            = !(win_valid_reg && !out_free);
    assign s_axis_tready = en;

    assign ctl.q_load  = en && s_axis_tvalid;
    assign ctl.acc_add = en && a_valid_reg;
    assign ctl.win_end = ctl.acc_add && (tick_reg == TICK_LAST);

    // Count ticks of the window and track stage occupancy
    always_comb
    begin
        a_valid_next   = en ? s_axis_tvalid : a_valid_reg;
        tick_next      = tick_reg;
        win_valid_next = win_valid_reg;
        if (ctl.win_end)
        begin
            tick_next = '0;
        end
        else if (ctl.acc_add)
        begin
            tick_next = tick_reg + 1'b1;
        end
        if (ctl.win_end)
        begin
            win_valid_next = 1'b1;
        end
        else if (win_move)
        begin
            win_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            tick_reg      <= '0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            tick_reg      <= tick_next;
            win_valid_reg <= win_valid_next;
        end
    end

    // Run one lane per sensor
    generate
        for (genvar i = 0; i < lsc_pkg::LANES; i++)
        begin : g_lane
            assign samples[i] = s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            assign levels[i]  = lsc_pkg::LEVEL_W'(levels_full[i]);

            lsc_lane #(
                .WINDOW_TICKS (WINDOW_TICKS),
                .SAMPLE_BITS  (SAMPLE_BITS)
            ) u_lane (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .sample       (samples[i]),
                .on_threshold (thr_reg),
                .level        (levels_full[i]),
                .digit        (digits[i])
            );
        end
    endgenerate

    // Merge lane results into the output item
    lsc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_move  (win_move),
        .digits    (digits),
        .levels    (levels),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    `LSC_ASSERT(a_tick_range, tick_reg <= TICK_LAST, "tick count past window end")
    `LSC_ASSERT_NEXT(a_win_held, win_valid_reg && !out_free, win_valid_reg, "held window lost")
    `LSC_ASSERT_NEXT(a_win_out, win_move, m_axis_tvalid, "moved window not presented")
    `LSC_ASSERT(a_code_range, !m_axis_tvalid || (m_axis_tdata[39:35] <= lsc_pkg::CODE_MAX),
                "reported code out of range")

endmodule

>>> src/lsc_lane.sv
// One sensor lane: scale, accumulate over the window, classify the level.
module lsc_lane #(
    parameter int WINDOW_TICKS = 16,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsc_pkg::lane_ctl_t           ctl,
    input  logic [SAMPLE_BITS-1:0]       sample,
    input  logic [lsc_pkg::THR_W-1:0]    on_threshold,
    output logic [SAMPLE_BITS-1:0]       level,
    output lsc_pkg::digit_t              digit
);

    // Division by the window length as a reciprocal multiply, exact for every sample
    localparam int SHIFT  = SAMPLE_BITS + $clog2(WINDOW_TICKS);
    localparam int MULT   = ((2 ** SHIFT) + WINDOW_TICKS - 1) / WINDOW_TICKS;
    localparam int PROD_W = SHIFT + SAMPLE_BITS;
    localparam int CMP_W  = (SAMPLE_BITS > lsc_pkg::THR_W) ? SAMPLE_BITS : lsc_pkg::THR_W;

    logic [PROD_W-1:0]      product;
    logic [SAMPLE_BITS-1:0] q_reg;
    logic [SAMPLE_BITS-1:0] acc_reg;
    logic [SAMPLE_BITS-1:0] acc_next;
    logic [SAMPLE_BITS-1:0] sum;
    logic [SAMPLE_BITS-1:0] level_reg;
    logic [CMP_W-1:0]       lv_ext;
    logic [CMP_W-1:0]       thr_ext;
    logic [CMP_W-1:0]       half_ext;

    // Scale the sample down by the window length
    assign product = PROD_W'(sample) * PROD_W'(MULT);

    // Hold the scaled sample for the accumulate stage
    always_ff @(posedge clk)
    begin
        if (ctl.q_load)
        begin
            q_reg <= product[SHIFT +: SAMPLE_BITS];
        end
    end

    // Accumulate; the window sum never exceeds the largest sample
    assign sum = acc_reg + q_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.win_end)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_add)
        begin
            acc_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Hold the finished window level
    always_ff @(posedge clk)
    begin
        if (ctl.win_end)
        begin
            level_reg <= sum;
        end
    end

    assign level = level_reg;

    // Classify against the threshold and its half
    assign lv_ext   = CMP_W'(level_reg);
    assign thr_ext  = CMP_W'(on_threshold);
    assign half_ext = CMP_W'(on_threshold >> 1);

    always_comb
    begin
        priority if (lv_ext < half_ext)
        begin
            digit = lsc_pkg::DIGIT_OFF;
        end
        else if (lv_ext < thr_ext)
        begin
            digit = lsc_pkg::DIGIT_BLINK;
        end
        else
        begin
            digit = lsc_pkg::DIGIT_ON;
        end
    end

endmodule

>>> src/lsc_merge.sv
// Merge of lane digits into the lamp code, chatter filter and output register.
module lsc_merge (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 win_move,
    input  lsc_pkg::digit_t [lsc_pkg::LANES-1:0]                 digits,
    input  logic [lsc_pkg::LANES-1:0][lsc_pkg::LEVEL_W-1:0]      levels,
    input  logic                                                 out_ready,
    output logic                                                 out_valid,
    output logic [lsc_pkg::OUT_DATA_W-1:0]                       out_data
);

    logic [lsc_pkg::CODE_W-1:0]     code;
    logic [lsc_pkg::CODE_W-1:0]     cand_reg;
    logic [lsc_pkg::CODE_W-1:0]     cand_next;
    logic                           cand_valid_reg;
    logic                           cand_valid_next;
    logic [lsc_pkg::CODE_W-1:0]     rep_reg;
    logic [lsc_pkg::CODE_W-1:0]     rep_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [lsc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [lsc_pkg::LEVEL_W-1:0]    value;

    // Sum the weighted digits of all lanes
    always_comb
    begin
        code = '0;
        for (int i = 0; i < lsc_pkg::LANES; i++)
        begin
            unique case (digits[i])
                lsc_pkg::DIGIT_BLINK: code = code + lsc_pkg::BLINK_WEIGHT[i];
                lsc_pkg::DIGIT_ON:    code = code + lsc_pkg::ON_WEIGHT[i];
                default:              code = code;
            endcase
        end
    end

    // Report a code once two windows agree; take the first one at once
    always_comb
    begin
        cand_next       = cand_reg;
        cand_valid_next = cand_valid_reg;
        rep_next        = rep_reg;
        if (win_move)
        begin
            priority if (!cand_valid_reg)
            begin
                cand_next       = code;
                rep_next        = code;
                cand_valid_next = 1'b1;
            end
            else if (code == cand_reg)
            begin
                rep_next = cand_reg;
            end
            else
            begin
                cand_next = code;
            end
        end
    end

    assign value = (rep_next == lsc_pkg::CODE_REPORT) ? levels[0] : '0;

    // Keep the output item until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (win_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg       <= '0;
            cand_valid_reg <= 1'b0;
            rep_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cand_reg       <= cand_next;
            cand_valid_reg <= cand_valid_next;
            rep_reg        <= rep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Load the output payload with the new window
    always_ff @(posedge clk)
    begin
        if (win_move)
        begin
            out_data_reg <= lsc_pkg::OUT_DATA_W'({value, rep_next, code,
                                                  levels[2], levels[1], levels[0]});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> bench/lamp_result_check.sv
// Result checker of the lamp state classifier: predicts each window result and compares it.
module lamp_result_check #(
    parameter int IN_W = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // sample_a, sample_b, sample_c from bit 0 up
    input  logic [IN_W-1:0]                s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // level_a, level_b, level_c, raw_code, reported_code, reported_value from bit 0 up
    input  logic [lsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lsc_pkg::THR_W-1:0]      cfg_data,
    output int                             mismatches,
    output int                             pending_windows
);
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    localparam int TICKS       = 16;
    localparam int SMP_W       = 10;
    localparam int PRINT_LIMIT = 60;

    // Base-3 place of each lamp digit
    localparam logic [CODE_W-1:0] LAMP_PLACE [LANES] = '{5'd1, 5'd3, 5'd9};

    // One window result, level_a in the lowest bits
    typedef struct packed {
        logic [LEVEL_W-1:0] value;
        logic [CODE_W-1:0]  shown;
        logic [CODE_W-1:0]  raw;
        logic [LEVEL_W-1:0] level_c;
        logic [LEVEL_W-1:0] level_b;
        logic [LEVEL_W-1:0] level_a;
    } window_result_t;

    // Predicted state of the block
    logic [LEVEL_W-1:0] level_sum [LANES];
    int                 tick_in_window;
    logic [CODE_W-1:0]  candidate;
    logic               candidate_seen;
    logic [CODE_W-1:0]  shown_code;
    logic [THR_W-1:0]   on_level;
    int                 windows_done;

    window_result_t     window_queue [$];

    initial
    begin
        mismatches      = 0;
        pending_windows = 0;
        windows_done    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("window %0d %s: got %0d, expected %0d",
                                      windows_done, field, got, want));
    endtask

    // Return the predictor to its reset state
    function void clear_prediction();
        for (int j = 0; j < LANES; j++)
            level_sum[j] = '0;
        tick_in_window = 0;
        candidate      = '0;
        candidate_seen = 1'b0;
        shown_code     = '0;
        on_level       = THR_RESET;
    endfunction

    // Accumulate one tick; on the last tick of a window queue the expected result
    function void take_tick(input logic [3*SMP_W-1:0] word);
        logic [SMP_W-1:0]  smp;
        logic [CODE_W-1:0] code;
        digit_t            digit;
        window_result_t    r;

        for (int j = 0; j < LANES; j++)
        begin
            smp          = word[j*SMP_W +: SMP_W];
            level_sum[j] = level_sum[j] + LEVEL_W'(smp / TICKS);
        end
        tick_in_window++;
        if (tick_in_window < TICKS)
            return;

        // Classify each lane and weight its digit
        code = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (level_sum[j] < (on_level >> 1))
                digit = DIGIT_OFF;
            else if (level_sum[j] < on_level)
                digit = DIGIT_BLINK;
            else
                digit = DIGIT_ON;
            code = code + CODE_W'(digit) * LAMP_PLACE[j];
        end

        // Chatter filter: first code goes through, later ones need two in a row
        if (!candidate_seen)
        begin
            candidate      = code;
            shown_code     = code;
            candidate_seen = 1'b1;
        end
        else if (code == candidate)
            shown_code = candidate;
        else
            candidate = code;

        r.level_a = level_sum[0];
        r.level_b = level_sum[1];
        r.level_c = level_sum[2];
        r.raw     = code;
        r.shown   = shown_code;
        r.value   = (shown_code == CODE_REPORT) ? level_sum[0] : '0;
        window_queue.push_back(r);

        for (int j = 0; j < LANES; j++)
            level_sum[j] = '0;
        tick_in_window = 0;
    endfunction

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        window_result_t got;
        window_result_t want;

        if (!rst_n)
        begin
            clear_prediction();
            window_queue.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = window_result_t'(m_axis_tdata[$bits(window_result_t)-1:0]);
                if (window_queue.size() == 0)
                    report_mismatch($sformatf("result with nothing expected, raw code %0d",
                                              got.raw));
                else
                begin
                    want = window_queue.pop_front();
                    compare_field("level_a", got.level_a, want.level_a);
                    compare_field("level_b", got.level_b, want.level_b);
                    compare_field("level_c", got.level_c, want.level_c);
                    compare_field("raw_code", got.raw, want.raw);
                    compare_field("reported_code", got.shown, want.shown);
                    compare_field("reported_value", got.value, want.value);
                end
                windows_done++;
            end
            if (cfg_valid && cfg_ready)
                on_level = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                take_tick(s_axis_tdata[3*SMP_W-1:0]);
        end
        pending_windows = window_queue.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the lamp state classifier bench: clock, reset, stimulus, stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    localparam int SAMPLE_BITS     = 10;
    localparam int IN_W            = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int TICKS           = 16;
    localparam int LEVEL_TOP       = 1008;
    localparam int NOISE           = -1;
    localparam int RANDOM_WINDOWS  = 43;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int IDLE_LIMIT      = 2000;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // sample_a, sample_b, sample_c from bit 0 up, zero padded to bytes
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // level_a, level_b, level_c, raw_code, reported_code, reported_value from bit 0 up
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [THR_W-1:0]      cfg_data      = '0;

    int mismatch_count;
    int pending_windows;

    // Stimulus state
    int lamp_plan [3];
    int cur_threshold = 512;
    bit burst;
    bit hold_off_req;
    bit hold_off_done;

    lamp_state_classifier #(
        .WINDOW_TICKS (TICKS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    lamp_result_check #(
        .IN_W (IN_W)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatch_count),
        .pending_windows (pending_windows)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_level(input int v);
        if (v < 0)
            return 0;
        if (v > LEVEL_TOP)
            return LEVEL_TOP;
        return v;
    endfunction

    // Sample of one tick so that the window sums to the planned level
    function automatic logic [SAMPLE_BITS-1:0] sample_for(input int level, input int tick);
        int q;
        if (level < 0)
            return SAMPLE_BITS'($urandom_range(0, 1023));
        q = level / TICKS + ((tick < level % TICKS) ? 1 : 0);
        return SAMPLE_BITS'(q * TICKS + $urandom_range(0, TICKS - 1));
    endfunction

    // Planned level of one lane, biased toward the classification bounds
    function automatic int pick_level();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return LEVEL_TOP;
            2: return clamp_level(cur_threshold / 2 + $urandom_range(0, 4) - 2);
            3: return clamp_level(cur_threshold + $urandom_range(0, 4) - 2);
            4: return $urandom_range(0, LEVEL_TOP);
            5: return NOISE;
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return 1023;
            3: return 2;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // Offer one tick item and hold it until accepted
    task automatic push_tick(input logic [SAMPLE_BITS-1:0] a, b, c);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({c, b, a});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_ticks(input int first, input int last);
        for (int t = first; t <= last; t++)
            push_tick(sample_for(lamp_plan[0], t), sample_for(lamp_plan[1], t),
                      sample_for(lamp_plan[2], t));
    endtask

    task automatic run_window(input int a, b, c);
        lamp_plan[0] = a;
        lamp_plan[1] = b;
        lamp_plan[2] = c;
        send_ticks(0, TICKS - 1);
    endtask

    // Drain the block, let the pipeline settle, then write the threshold
    task automatic write_threshold(input int v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_windows != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= THR_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        cur_threshold = v;
    endtask

    // Result side: random ready pattern with one long hold-off
    initial
    begin
        int r;
        int run;
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    m_axis_tready <= 1'b1;
                    run = $urandom_range(1, 20);
                end
                else if (r < 55)
                begin
                    m_axis_tready <= 1'b1;
                    run = $urandom_range(50, 100);
                end
                else if (r < 88)
                begin
                    m_axis_tready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    run = $urandom_range(10, 40);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    // Abort when no channel moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("lamp_state_classifier test failed");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int split;

        burst = 1'b0;
        hold_off_req = 1'b0;
        hold_off_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First window is reported at once; a lone change keeps the old report
        run_window(LEVEL_TOP, 0, 0);
        run_window(255, 256, 511);
        run_window(255, 256, 511);
        run_window(512, 511, LEVEL_TOP);
        run_window(511, 512, 256);

        // Zero threshold: every lamp on
        write_threshold(0);
        run_window(0, 0, 0);
        run_window(NOISE, NOISE, NOISE);

        // Threshold of one: a zero level blinks
        write_threshold(1);
        run_window(0, 1, 0);
        run_window(0, 1, 0);

        // Top threshold written in the middle of a window
        lamp_plan[0] = LEVEL_TOP;
        lamp_plan[1] = 511;
        lamp_plan[2] = 510;
        send_ticks(0, 6);
        write_threshold(1023);
        send_ticks(7, TICKS - 1);

        write_threshold(512);

        // Random windows; kept plans give repeated codes for the filter
        for (int w = 0; w < RANDOM_WINDOWS; w++)
        begin
            burst = ($urandom_range(0, 3) == 0);
            if (w == 6)
                hold_off_req = 1'b1;
            if ($urandom_range(0, 7) == 0)
                write_threshold(pick_threshold());
            if (w == 0 || $urandom_range(0, 1) == 0)
                for (int ch = 0; ch < 3; ch++)
                    lamp_plan[ch] = pick_level();
            if ($urandom_range(0, 9) == 0)
            begin
                split = $urandom_range(1, TICKS - 1);
                send_ticks(0, split - 1);
                write_threshold(pick_threshold());
                send_ticks(split, TICKS - 1);
            end
            else
                send_ticks(0, TICKS - 1);
        end

        // Drain and decide
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_windows != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("lamp_state_classifier test passed");
        else
            $display("lamp_state_classifier test failed");
        $finish;
    end

endmodule
